[design/ctd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctd_pkg
// Shared types for the complex tolerance dedup block: channel words and the
// sequencer states.
// ----------------------------------------------------------------------------
package ctd_pkg;

	// Input word: one complex value in signed Q16.16
	typedef struct packed {
		logic signed [31:0] value_re;
		logic signed [31:0] value_im;
		logic               last;
	} ctd_in_t;

	// Result word
	typedef struct packed {
		logic        is_unique;
		logic [5:0]  slot;
		logic        store_overflow;
		logic        vector_done;
		logic [6:0]  unique_total;
		logic [15:0] duplicate_total;
	} ctd_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_SCAN,
		ST_DONE
	} ctd_state_t;

	localparam logic [2:0]  PREP_LAST = 3'd6;
	localparam logic [15:0] DUP_MAX   = 16'hFFFF;
	localparam logic [31:0] TOL_RESET = 32'd66;

endpackage

[design/complex_tolerance_dedup.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_tolerance_dedup
// Removes near-duplicate complex values from a stream, keeping a ring of
// unique entries per vector.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per complex value; in_stall is high while an item is
//           in work. Mark the final value of a vector with last.
//   out_* : one result word per input word, held while out_stall is high.
//   cfg_* : tolerance write, taken at any cycle (cfg_ready is always high);
//           write it only while the block is idle.
// Sequence:
//   One item at a time. After accept, the bound products are formed on one
//   shared 32x32 multiplier, then one full turn of the entry ring passes the
//   distance unit, its pipeline drains, and a final store/report state
//   writes the result. The block returns to idle before the next accept, so
//   a new item is taken only after the last one is through. The ring turn
//   sets the rate.
// Reset:
//   Clears the counts and the output valid flag and sets tolerance to 66.
//   The entries need no clearing; only slots below the count are tested.
//   A stalled result holds the block in its final cycle; the next input is
//   accepted only once that result has moved into the output register.
// ----------------------------------------------------------------------------
module complex_tolerance_dedup
	import ctd_pkg::*;
#(
	parameter int MAX_UNIQUE = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  ctd_in_t  in_data,
	output logic     out_valid,
	input  logic     out_stall,
	output ctd_out_t out_data,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  logic [31:0] cfg_data
);

	localparam int IW = (MAX_UNIQUE > 1) ? $clog2(MAX_UNIQUE) : 1;
	localparam int CW = $clog2(MAX_UNIQUE + 1);
	localparam int SW = $clog2(MAX_UNIQUE + 3);

	ctd_state_t state_q, state_d;

	logic [31:0]   tol_q;
	logic [31:0]   re_q;
	logic [31:0]   im_q;
	logic          last_q;
	logic [2:0]    step_q;
	logic [SW-1:0] scan_q;
	logic [CW-1:0] count_q;
	logic [15:0]   dup_q;
	logic          found_q;
	logic [IW-1:0] found_idx_q;
	logic [63:0]   tol2_q;
	logic [63:0]   zmag2_q;
	logic [127:0]  rel_q;
	logic          out_valid_q;
	ctd_out_t      out_q;

	logic          in_take;
	logic          prep_go;
	logic          scan_go;
	logic          finish;
	logic          shift;
	logic          issue;
	logic          hit;
	logic [IW-1:0] hit_idx;
	logic          out_free;
	logic [31:0]   are;
	logic [31:0]   aim;
	logic [31:0]   mul_a;
	logic [31:0]   mul_b;
	logic [63:0]   prod;
	logic          unique_v;
	logic          store_v;
	logic [CW-1:0] count_v;
	logic [15:0]   dup_v;
	logic [CW-1:0] slot_v;
	ctd_out_t      res_v;

	logic [31:0] ring_re [MAX_UNIQUE];
	logic [31:0] ring_im [MAX_UNIQUE];

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;
	assign in_take   = in_valid && !in_stall;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		prep_go  = 1'b0;
		scan_go  = 1'b0;
		finish   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				prep_go = 1'b1;
				if (step_q == PREP_LAST) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				scan_go = 1'b1;
				if (scan_q == SW'(MAX_UNIQUE + 2)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tol_q <= cfg_data;
		end
	end

	// hold the accepted word
	always_ff @(posedge clk) begin
		if (in_take) begin
			re_q   <= in_data.value_re;
			im_q   <= in_data.value_im;
			last_q <= in_data.last;
		end
	end

	// shared multiplier for the bound products
	assign are = re_q[31] ? (32'd0 - re_q) : re_q;
	assign aim = im_q[31] ? (32'd0 - im_q) : im_q;

	always_comb begin
		case (step_q)
			3'd0:    begin mul_a = tol_q;          mul_b = tol_q;           end
			3'd1:    begin mul_a = are;            mul_b = are;             end
			3'd2:    begin mul_a = aim;            mul_b = aim;             end
			3'd3:    begin mul_a = tol2_q[31:0];   mul_b = zmag2_q[31:0];   end
			3'd4:    begin mul_a = tol2_q[31:0];   mul_b = zmag2_q[63:32];  end
			3'd5:    begin mul_a = tol2_q[63:32];  mul_b = zmag2_q[31:0];   end
			3'd6:    begin mul_a = tol2_q[63:32];  mul_b = zmag2_q[63:32];  end
			default: begin mul_a = 32'd0;          mul_b = 32'd0;           end
		endcase
	end

	assign prod = 64'(mul_a) * 64'(mul_b);

	// accumulate tol^2, |z|^2 and tol^2 * |z|^2
	always_ff @(posedge clk) begin
		if (prep_go) begin
			case (step_q)
				3'd0:    tol2_q  <= prod;
				3'd1:    zmag2_q <= prod;
				3'd2:    zmag2_q <= zmag2_q + prod;
				3'd3:    rel_q   <= {64'd0, prod};
				3'd4:    rel_q   <= rel_q + {32'd0, prod, 32'd0};
				3'd5:    rel_q   <= rel_q + {32'd0, prod, 32'd0};
				3'd6:    rel_q   <= rel_q + {prod, 64'd0};
				default: rel_q   <= rel_q;
			endcase
		end
	end

	// step and scan counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 3'd0;
			scan_q <= '0;
		end else begin
			if (in_take) begin
				step_q <= 3'd0;
			end else if (prep_go) begin
				step_q <= step_q + 3'd1;
			end
			if (in_take) begin
				scan_q <= '0;
			end else if (scan_go) begin
				scan_q <= scan_q + SW'(1);
			end
		end
	end

	// ring turns once per item; only stored slots are tested
	assign shift = scan_go && (scan_q < SW'(MAX_UNIQUE));
	assign issue = shift && (scan_q < SW'(count_q));

	// entry ring
	for (genvar k = 0; k < MAX_UNIQUE; k++) begin : g_ring
		ctd_cell u_cell (
			.clk    (clk),
			.shift  (shift),
			.wr_en  (finish && store_v && (count_q == CW'(k))),
			.wr_re  (re_q),
			.wr_im  (im_q),
			.nb_re  (ring_re[(k + 1) % MAX_UNIQUE]),
			.nb_im  (ring_im[(k + 1) % MAX_UNIQUE]),
			.ent_re (ring_re[k]),
			.ent_im (ring_im[k])
		);
	end

	ctd_cmp #(
		.IW (IW)
	) u_cmp (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (issue),
		.idx       (IW'(scan_q)),
		.ent_re    (ring_re[0]),
		.ent_im    (ring_im[0]),
		.val_re    (re_q),
		.val_im    (im_q),
		.tol2      (tol2_q),
		.rel_bound (rel_q),
		.hit       (hit),
		.hit_idx   (hit_idx)
	);

	// keep the first match
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (in_take) begin
			found_q <= 1'b0;
		end else if (hit) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (hit && !found_q) begin
			found_idx_q <= hit_idx;
		end
	end

	// result and updated counts
	always_comb begin
		unique_v = !found_q;
		store_v  = unique_v && (count_q < CW'(MAX_UNIQUE));
		count_v  = store_v ? count_q + CW'(1) : count_q;
		dup_v    = (!unique_v && dup_q != DUP_MAX) ? dup_q + 16'd1 : dup_q;
		if (!unique_v) begin
			slot_v = CW'(found_idx_q);
		end else if (store_v) begin
			slot_v = count_q;
		end else begin
			slot_v = '0;
		end
		res_v.is_unique       = unique_v;
		res_v.slot            = 6'(slot_v);
		res_v.store_overflow  = unique_v && !store_v;
		res_v.vector_done     = last_q;
		res_v.unique_total    = last_q ? 7'(count_v) : 7'd0;
		res_v.duplicate_total = last_q ? dup_v : 16'd0;
	end

	// counts; clear after the last word of a vector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			dup_q   <= 16'd0;
		end else if (finish) begin
			count_q <= last_q ? '0 : count_v;
			dup_q   <= last_q ? 16'd0 : dup_v;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_q <= res_v;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[design/ctd_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctd_cell
// One storage cell of the entry ring. Takes its neighbor's entry on a shift
// or a new entry on a write.
// ----------------------------------------------------------------------------
module ctd_cell (
	input  logic        clk,
	input  logic        shift,
	input  logic        wr_en,
	input  logic [31:0] wr_re,
	input  logic [31:0] wr_im,
	input  logic [31:0] nb_re,
	input  logic [31:0] nb_im,
	output logic [31:0] ent_re,
	output logic [31:0] ent_im
);

	logic [31:0] re_q;
	logic [31:0] im_q;

	// load new entry, or advance ring
	always_ff @(posedge clk) begin
		if (wr_en) begin
			re_q <= wr_re;
			im_q <= wr_im;
		end else if (shift) begin
			re_q <= nb_re;
			im_q <= nb_im;
		end
	end

	assign ent_re = re_q;
	assign ent_im = im_q;

endmodule

[design/ctd_cmp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctd_cmp
// Distance test at the head of the ring: three stages computing the squared
// distance and checking it against the relative and absolute bounds.
// ----------------------------------------------------------------------------
module ctd_cmp #(
	parameter int IW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          issue,
	input  logic [IW-1:0] idx,
	input  logic [31:0]   ent_re,
	input  logic [31:0]   ent_im,
	input  logic [31:0]   val_re,
	input  logic [31:0]   val_im,
	input  logic [63:0]   tol2,
	input  logic [127:0]  rel_bound,
	output logic          hit,
	output logic [IW-1:0] hit_idx
);

	logic [32:0]  dr;
	logic [32:0]  di;
	logic [32:0]  adr_s1;
	logic [32:0]  adi_s1;
	logic         vld_s1;
	logic [IW-1:0] idx_s1;
	logic [65:0]  sqr_s2;
	logic [65:0]  sqi_s2;
	logic         vld_s2;
	logic [IW-1:0] idx_s2;
	logic [65:0]  d2;
	logic         rel_hit;
	logic         abs_hit;
	logic         hit_s3;
	logic [IW-1:0] idx_s3;

	// differences, sign-extended to 33 bits
	assign dr = {val_re[31], val_re} - {ent_re[31], ent_re};
	assign di = {val_im[31], val_im} - {ent_im[31], ent_im};

	// stage 1: magnitudes of the differences
	always_ff @(posedge clk) begin
		adr_s1 <= dr[32] ? (33'd0 - dr) : dr;
		adi_s1 <= di[32] ? (33'd0 - di) : di;
		idx_s1 <= idx;
	end

	// stage 2: squares
	always_ff @(posedge clk) begin
		sqr_s2 <= 66'(adr_s1) * 66'(adr_s1);
		sqi_s2 <= 66'(adi_s1) * 66'(adi_s1);
		idx_s2 <= idx_s1;
	end

	// stage 3: sum and compare against both bounds
	assign d2      = sqr_s2 + sqi_s2;
	assign rel_hit = {30'd0, d2, 32'd0} < rel_bound;
	assign abs_hit = d2 < {2'd0, tol2};

	always_ff @(posedge clk) begin
		idx_s3 <= idx_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			hit_s3 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			hit_s3 <= vld_s2 && (rel_hit || abs_hit);
		end
	end

	assign hit     = hit_s3;
	assign hit_idx = idx_s3;

endmodule
